// ----- rtl/core/sm4_pkg.sv -----
// sm4 cipher package: payload types, register codes, constant tables and round functions
package sm4_pkg;

  typedef struct packed {
    logic [31:0] in_word0;
    logic [31:0] in_word1;
    logic [31:0] in_word2;
    logic [31:0] in_word3;
  } in_word_t;

  typedef struct packed {
    logic [31:0] out_word0;
    logic [31:0] out_word1;
    logic [31:0] out_word2;
    logic [31:0] out_word3;
  } out_word_t;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned ROUNDS    = 32;
  localparam int unsigned RND_W     = $clog2(ROUNDS);

  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 3'd4;

  localparam logic [31:0] FK [4] = '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc};

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  // byte-wise s-box over a word
  function automatic logic [31:0] tau(input logic [31:0] v);
    return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  // linear transform of the data rounds
  function automatic logic [31:0] l_data(input logic [31:0] b);
    return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]} ^
           {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
  endfunction

  // linear transform of the key schedule
  function automatic logic [31:0] l_key(input logic [31:0] b);
    return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
  endfunction

  // ck byte j of round i is 7*(4i+j) mod 256
  function automatic logic [31:0] ck_word(input logic [RND_W-1:0] i);
    logic [31:0] w;
    logic [9:0]  p;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      p = {3'b000, i, 2'(j)} * 10'd7;
      w = {w[23:0], p[7:0]};
    end
    return w;
  endfunction

endpackage

// ----- rtl/core/sm4_block_cipher_core.sv -----
// sm4 block cipher core: iterative round engine with on-demand key schedule
//
//  channel  direction  handshake             word
//  in_      input      in_valid / in_stall   sm4_pkg::in_word_t, plaintext or ciphertext
//  out_     output     out_valid / out_stall sm4_pkg::out_word_t, result block
//  cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data (key words, decrypt mode)
//
// after an accept, a block runs 32 rounds through the single shared round unit, then the
// output register is loaded before the next accept.
// the first block after a key word write first runs 32 key schedule rounds through
// the same unit plus one round key store read before the data rounds.
// rst_n is synchronous; the round key store is not cleared, keys are rebuilt on demand.
// in_stall is high while a block is in flight; a held result only delays the output load.
module sm4_block_cipher_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  sm4_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output sm4_pkg::out_word_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sm4_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_KEXP  = 3'd1;
  localparam logic [2:0] ST_PREP  = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic [sm4_pkg::RND_W-1:0] LAST_RND = sm4_pkg::RND_W'(sm4_pkg::ROUNDS - 1);

  logic [2:0]                  state_r, state_nxt;
  logic [sm4_pkg::RND_W-1:0]   round_cnt_r, round_cnt_nxt;
  logic                        keys_ready_r, keys_ready_nxt;
  logic                        decrypt_r;
  logic [31:0]                 key_r [4];
  logic [31:0]                 work_r [4];
  sm4_pkg::in_word_t           blk_r;
  logic [31:0]                 rk_mem_r [sm4_pkg::ROUNDS];
  logic [31:0]                 rk_r;
  logic [sm4_pkg::RND_W-1:0]   rd_addr;
  logic [sm4_pkg::RND_W-1:0]   rd_round;
  logic                        out_valid_r;
  sm4_pkg::out_word_t          out_data_r;
  logic                        in_accept;
  logic                        out_free;
  logic                        key_sel;
  logic [31:0]                 mix;
  logic [31:0]                 sub;
  logic [31:0]                 new_word;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  // shared round unit, key schedule or data round
  assign key_sel  = (state_r == ST_KEXP);
  assign mix      = work_r[1] ^ work_r[2] ^ work_r[3] ^
                    (key_sel ? sm4_pkg::ck_word(round_cnt_r) : rk_r);
  assign sub      = sm4_pkg::tau(mix);
  assign new_word = work_r[0] ^ (key_sel ? sm4_pkg::l_key(sub) : sm4_pkg::l_data(sub));

  // round key prefetch: in a data round, fetch the key of the following round
  assign rd_round = (state_r == ST_ROUND) ? round_cnt_r + 1'b1 : '0;
  assign rd_addr  = decrypt_r ? ~rd_round : rd_round;

  always_comb begin
    state_nxt      = state_r;
    round_cnt_nxt  = round_cnt_r;
    keys_ready_nxt = keys_ready_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = keys_ready_r ? ST_ROUND : ST_KEXP;
        end
      end
      ST_KEXP: begin
        round_cnt_nxt = round_cnt_r + 1'b1;
        if (round_cnt_r == LAST_RND) begin
          state_nxt      = ST_PREP;
          keys_ready_nxt = 1'b1;
        end
      end
      ST_PREP: begin
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        round_cnt_nxt = round_cnt_r + 1'b1;
        if (round_cnt_r == LAST_RND) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // a new key word forces a fresh schedule
    if (cfg_valid && cfg_ready && cfg_index <= sm4_pkg::REG_KEY_WORD3) begin
      keys_ready_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      round_cnt_r  <= '0;
      keys_ready_r <= 1'b0;
      decrypt_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        key_r[i]  <= '0;
        work_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      round_cnt_r  <= round_cnt_nxt;
      keys_ready_r <= keys_ready_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sm4_pkg::REG_KEY_WORD0:    key_r[0]  <= cfg_data;
          sm4_pkg::REG_KEY_WORD1:    key_r[1]  <= cfg_data;
          sm4_pkg::REG_KEY_WORD2:    key_r[2]  <= cfg_data;
          sm4_pkg::REG_KEY_WORD3:    key_r[3]  <= cfg_data;
          sm4_pkg::REG_DECRYPT_MODE: decrypt_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            if (keys_ready_r) begin
              work_r[0] <= in_data.in_word0;
              work_r[1] <= in_data.in_word1;
              work_r[2] <= in_data.in_word2;
              work_r[3] <= in_data.in_word3;
            end else begin
              for (int i = 0; i < 4; i++) begin
                work_r[i] <= key_r[i] ^ sm4_pkg::FK[i];
              end
            end
          end
        end
        ST_PREP: begin
          work_r[0] <= blk_r.in_word0;
          work_r[1] <= blk_r.in_word1;
          work_r[2] <= blk_r.in_word2;
          work_r[3] <= blk_r.in_word3;
        end
        ST_KEXP, ST_ROUND: begin
          work_r[0] <= work_r[1];
          work_r[1] <= work_r[2];
          work_r[2] <= work_r[3];
          work_r[3] <= new_word;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      blk_r <= in_data;
    end
    if (state_r == ST_OUT && out_free) begin
      out_data_r.out_word0 <= work_r[3];
      out_data_r.out_word1 <= work_r[2];
      out_data_r.out_word2 <= work_r[1];
      out_data_r.out_word3 <= work_r[0];
    end
  end

  // round key store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (state_r == ST_KEXP) begin
      rk_mem_r[round_cnt_r] <= new_word;
    end
    rk_r <= rk_mem_r[rd_addr];
  end

  a_idle_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> round_cnt_r == '0)
    else $error("round counter not zero while idle");

  a_prep_keys: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PREP |-> keys_ready_r)
    else $error("data rounds prepared without a finished key schedule");

  a_ready_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && keys_ready_r) |=> state_r == ST_ROUND)
    else $error("key schedule rerun with keys ready");

  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result shown outside the output load");

  a_stale_keys: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !keys_ready_r) |=> state_r == ST_KEXP)
    else $error("block started on a stale key schedule");

endmodule

// ----- bench/testbench.sv -----
// self-checking bench for the sm4 block cipher core: known answers, predictor, random traffic
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASES         = 20;
  localparam int PHASE_BLOCKS   = 30;
  localparam int QUIET_PHASES   = 3;

  // indexes that decode to no register
  localparam logic [sm4_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [sm4_pkg::CFG_IDX_W-1:0] REG_SPARE_MID = 3'd6;
  localparam logic [sm4_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [sm4_pkg::CFG_IDX_W-1:0] KEY_REGS [4] =
    '{sm4_pkg::REG_KEY_WORD0, sm4_pkg::REG_KEY_WORD1, sm4_pkg::REG_KEY_WORD2,
      sm4_pkg::REG_KEY_WORD3};

  // standard published vector: key equals plaintext
  localparam logic [127:0] STD_TEXT   = 128'h0123456789abcdeffedcba9876543210;
  localparam logic [127:0] STD_CIPHER = 128'h681edf34d206965e86b3e94f536e4246;

  localparam logic [31:0] FK_MASK [4] =
    '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc};

  localparam logic [7:0] SUB_TAB [256] = '{
    'hd6,'h90,'he9,'hfe,'hcc,'he1,'h3d,'hb7,'h16,'hb6,'h14,'hc2,'h28,'hfb,'h2c,'h05,
    'h2b,'h67,'h9a,'h76,'h2a,'hbe,'h04,'hc3,'haa,'h44,'h13,'h26,'h49,'h86,'h06,'h99,
    'h9c,'h42,'h50,'hf4,'h91,'hef,'h98,'h7a,'h33,'h54,'h0b,'h43,'hed,'hcf,'hac,'h62,
    'he4,'hb3,'h1c,'ha9,'hc9,'h08,'he8,'h95,'h80,'hdf,'h94,'hfa,'h75,'h8f,'h3f,'ha6,
    'h47,'h07,'ha7,'hfc,'hf3,'h73,'h17,'hba,'h83,'h59,'h3c,'h19,'he6,'h85,'h4f,'ha8,
    'h68,'h6b,'h81,'hb2,'h71,'h64,'hda,'h8b,'hf8,'heb,'h0f,'h4b,'h70,'h56,'h9d,'h35,
    'h1e,'h24,'h0e,'h5e,'h63,'h58,'hd1,'ha2,'h25,'h22,'h7c,'h3b,'h01,'h21,'h78,'h87,
    'hd4,'h00,'h46,'h57,'h9f,'hd3,'h27,'h52,'h4c,'h36,'h02,'he7,'ha0,'hc4,'hc8,'h9e,
    'hea,'hbf,'h8a,'hd2,'h40,'hc7,'h38,'hb5,'ha3,'hf7,'hf2,'hce,'hf9,'h61,'h15,'ha1,
    'he0,'hae,'h5d,'ha4,'h9b,'h34,'h1a,'h55,'had,'h93,'h32,'h30,'hf5,'h8c,'hb1,'he3,
    'h1d,'hf6,'he2,'h2e,'h82,'h66,'hca,'h60,'hc0,'h29,'h23,'hab,'h0d,'h53,'h4e,'h6f,
    'hd5,'hdb,'h37,'h45,'hde,'hfd,'h8e,'h2f,'h03,'hff,'h6a,'h72,'h6d,'h6c,'h5b,'h51,
    'h8d,'h1b,'haf,'h92,'hbb,'hdd,'hbc,'h7f,'h11,'hd9,'h5c,'h41,'h1f,'h10,'h5a,'hd8,
    'h0a,'hc1,'h31,'h88,'ha5,'hcd,'h7b,'hbd,'h2d,'h74,'hd0,'h12,'hb8,'he5,'hb4,'hb0,
    'h89,'h69,'h97,'h4a,'h0c,'h96,'h77,'h7e,'h65,'hb9,'hf1,'h09,'hc5,'h6e,'hc6,'h84,
    'h18,'hf0,'h7d,'hec,'h3a,'hdc,'h4d,'h20,'h79,'hee,'h5f,'h3e,'hd7,'hcb,'h39,'h48
  };

  typedef enum logic {ROW_CFG, ROW_BLOCK} row_kind_t;

  typedef struct packed {
    row_kind_t                     kind;
    logic [sm4_pkg::CFG_IDX_W-1:0] idx;
    logic [31:0]                   data;
    sm4_pkg::in_word_t             blk;
    logic                          known;
    sm4_pkg::out_word_t            ans;
  } stim_row_t;

  localparam int DIR_ROWS = 28;

  // register rows drain the core first; block rows with known set carry a typed answer
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    {ROW_BLOCK, sm4_pkg::REG_KEY_WORD0, 32'h0, 128'h0, 1'b0, 128'h0},
    {ROW_BLOCK, sm4_pkg::REG_KEY_WORD0, 32'h0, {128{1'b1}}, 1'b0, 128'h0},
    {ROW_CFG, sm4_pkg::REG_KEY_WORD0, 32'h01234567, 128'h0, 1'b0, 128'h0},
    {ROW_CFG, sm4_pkg::REG_KEY_WORD1, 32'h89abcdef, 128'h0, 1'b0, 128'h0},
    {ROW_CFG, sm4_pkg::REG_KEY_WORD2, 32'hfedcba98, 128'h0, 1'b0, 128'h0},
    {ROW_CFG, sm4_pkg::REG_KEY_WORD3, 32'h76543210, 128'h0, 1'b0, 128'h0},
    {ROW_BLOCK, sm4_pkg::REG_KEY_WORD0, 32'h0, STD_TEXT, 1'b1, STD_CIPHER},
    {ROW_BLOCK, sm4_pkg::REG_KEY_WORD0, 32'h0, STD_TEXT, 1'b1, STD_CIPHER},
    {ROW_CFG, sm4_pkg::REG_DECRYPT_MODE, 32'h1, 128'h0, 1'b0, 128'h0},
    {ROW_BLOCK, sm4_pkg::REG_KEY_WORD0, 32'h0, STD_CIPHER, 1'b1, STD_TEXT},
    {ROW_CFG, REG_SPARE_LO, 32'hffffffff, 128'h0, 1'b0, 128'h0},
    {ROW_CFG, REG_SPARE_MID, 32'h00000000, 128'h0, 1'b0, 128'h0},
    {ROW_CFG, REG_SPARE_HI, 32'hffffffff, 128'h0, 1'b0, 128'h0},
    {ROW_BLOCK, sm4_pkg::REG_KEY_WORD0, 32'h0, STD_CIPHER, 1'b1, STD_TEXT},
    // only bit 0 of the mode register counts
    {ROW_CFG, sm4_pkg::REG_DECRYPT_MODE, 32'hfffffffe, 128'h0, 1'b0, 128'h0},
    {ROW_BLOCK, sm4_pkg::REG_KEY_WORD0, 32'h0, STD_TEXT, 1'b1, STD_CIPHER},
    {ROW_CFG, sm4_pkg::REG_KEY_WORD0, 32'hffffffff, 128'h0, 1'b0, 128'h0},
    {ROW_CFG, sm4_pkg::REG_KEY_WORD1, 32'hffffffff, 128'h0, 1'b0, 128'h0},
    {ROW_CFG, sm4_pkg::REG_KEY_WORD2, 32'hffffffff, 128'h0, 1'b0, 128'h0},
    {ROW_CFG, sm4_pkg::REG_KEY_WORD3, 32'hffffffff, 128'h0, 1'b0, 128'h0},
    {ROW_BLOCK, sm4_pkg::REG_KEY_WORD0, 32'h0, 128'h0, 1'b0, 128'h0},
    {ROW_BLOCK, sm4_pkg::REG_KEY_WORD0, 32'h0,
     128'h80000000_00000001_7fffffff_fffffffe, 1'b0, 128'h0},
    // mode change alone keeps the expanded keys
    {ROW_CFG, sm4_pkg::REG_DECRYPT_MODE, 32'hffffffff, 128'h0, 1'b0, 128'h0},
    {ROW_BLOCK, sm4_pkg::REG_KEY_WORD0, 32'h0, {128{1'b1}}, 1'b0, 128'h0},
    // one key word change forces a new schedule
    {ROW_CFG, sm4_pkg::REG_KEY_WORD2, 32'h00000000, 128'h0, 1'b0, 128'h0},
    {ROW_BLOCK, sm4_pkg::REG_KEY_WORD0, 32'h0,
     128'h55555555_aaaaaaaa_0f0f0f0f_f0f0f0f0, 1'b0, 128'h0},
    {ROW_CFG, sm4_pkg::REG_DECRYPT_MODE, 32'h0, 128'h0, 1'b0, 128'h0},
    {ROW_BLOCK, sm4_pkg::REG_KEY_WORD0, 32'h0,
     128'h55555555_aaaaaaaa_0f0f0f0f_f0f0f0f0, 1'b0, 128'h0}
  };

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  sm4_pkg::in_word_t             in_data;
  logic                          out_valid;
  logic                          out_stall;
  sm4_pkg::out_word_t            out_data;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [sm4_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0]                   cfg_data;

  sm4_block_cipher_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state, mirrors the core's registers
  logic [31:0] cipher_key [4] = '{32'h0, 32'h0, 32'h0, 32'h0};
  logic        decrypt_sel    = 1'b0;
  logic [31:0] round_key [32];
  logic        keys_built     = 1'b0;

  sm4_pkg::out_word_t expected_blocks [$];
  logic               known_pending;
  sm4_pkg::out_word_t known_ans;
  bit                 idle_on;
  bit                 hold_req;
  int                 fault_count    = 0;
  int                 blocks_checked = 0;
  int                 known_checked  = 0;
  int                 key_loads      = 0;
  int                 reg_writes     = 0;
  int                 stall_cycles   = 0;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] sub_bytes(input logic [31:0] v);
    return {SUB_TAB[v[31:24]], SUB_TAB[v[23:16]], SUB_TAB[v[15:8]], SUB_TAB[v[7:0]]};
  endfunction

  function automatic logic [31:0] round_const(input int i);
    logic [31:0] w;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      w = (w << 8) | ((7 * (4 * i + j)) & 255);
    end
    return w;
  endfunction

  task automatic expand_schedule();
    logic [31:0] k [4];
    logic [31:0] b;
    logic [31:0] nk;
    for (int i = 0; i < 4; i++) k[i] = cipher_key[i] ^ FK_MASK[i];
    for (int i = 0; i < 32; i++) begin
      b  = sub_bytes(k[1] ^ k[2] ^ k[3] ^ round_const(i));
      nk = k[0] ^ b ^ rotl32(b, 13) ^ rotl32(b, 23);
      round_key[i] = nk;
      k[0] = k[1];
      k[1] = k[2];
      k[2] = k[3];
      k[3] = nk;
    end
    keys_built = 1'b1;
  endtask

  task automatic predict_block(input sm4_pkg::in_word_t blk, output sm4_pkg::out_word_t res);
    logic [31:0] x [4];
    logic [31:0] rk;
    logic [31:0] b;
    logic [31:0] nx;
    if (!keys_built) expand_schedule();
    x[0] = blk.in_word0;
    x[1] = blk.in_word1;
    x[2] = blk.in_word2;
    x[3] = blk.in_word3;
    for (int r = 0; r < 32; r++) begin
      rk = decrypt_sel ? round_key[31 - r] : round_key[r];
      b  = sub_bytes(x[1] ^ x[2] ^ x[3] ^ rk);
      nx = x[0] ^ b ^ rotl32(b, 2) ^ rotl32(b, 10) ^ rotl32(b, 18) ^ rotl32(b, 24);
      x[0] = x[1];
      x[1] = x[2];
      x[2] = x[3];
      x[3] = nx;
    end
    res.out_word0 = x[3];
    res.out_word1 = x[2];
    res.out_word2 = x[1];
    res.out_word3 = x[0];
  endtask

  task automatic apply_write(input logic [sm4_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
    case (idx)
      sm4_pkg::REG_KEY_WORD0, sm4_pkg::REG_KEY_WORD1, sm4_pkg::REG_KEY_WORD2,
      sm4_pkg::REG_KEY_WORD3: begin
        cipher_key[idx[1:0]] = data;
        keys_built = 1'b0;
        key_loads++;
      end
      sm4_pkg::REG_DECRYPT_MODE: decrypt_sel = data[0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hffffffff;
      2: return 32'h1 << $urandom_range(0, 31);
      3: return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  function automatic sm4_pkg::in_word_t rand_block();
    sm4_pkg::in_word_t blk;
    blk.in_word0 = rand_word();
    blk.in_word1 = rand_word();
    blk.in_word2 = rand_word();
    blk.in_word3 = rand_word();
    return blk;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // accept tracking, result checks and the watchdog
  always @(posedge clk) begin : track
    sm4_pkg::out_word_t pred;
    sm4_pkg::out_word_t want;
    logic [31:0]        w4 [4];
    logic [31:0]        g4 [4];
    bit                 moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        apply_write(cfg_index, cfg_data);
        reg_writes++;
        moved = 1'b1;
      end
      if (in_valid && !in_stall) begin
        predict_block(in_data, pred);
        expected_blocks.push_back(known_pending ? known_ans : pred);
        if (known_pending) known_checked++;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_blocks.size() == 0) begin
          $display("%0t unexpected word: expected none, actual %h", $realtime, out_data);
          fault_count++;
        end else begin
          want = expected_blocks.pop_front();
          w4 = '{want.out_word0, want.out_word1, want.out_word2, want.out_word3};
          g4 = '{out_data.out_word0, out_data.out_word1, out_data.out_word2,
                 out_data.out_word3};
          for (int i = 0; i < 4; i++) begin
            if (w4[i] !== g4[i]) begin
              $display("%0t out_word%0d mismatch: expected %h, actual %h",
                       $realtime, i, w4[i], g4[i]);
              fault_count++;
            end
          end
          blocks_checked++;
        end
      end
    end
    stall_cycles = moved ? 0 : stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no handshake for %0d cycles, %0d words outstanding",
               $realtime, stall_cycles, expected_blocks.size());
      $display("testbench: errors");
      $finish;
    end
  end

  // receiver: random stall bursts and one long hold on request
  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_block(input sm4_pkg::in_word_t blk, input logic has_known,
                            input sm4_pkg::out_word_t ans);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_data       <= blk;
    known_pending <= has_known;
    known_ans     <= ans;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering and wait for every outstanding word
  task automatic settle();
    @(negedge clk);
    in_valid      <= 1'b0;
    known_pending <= 1'b0;
    while (expected_blocks.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [sm4_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic retune(input int ph);
    case (ph)
      0: begin
        for (int k = 0; k < 4; k++) cfg_write(KEY_REGS[k], 32'h0);
        cfg_write(sm4_pkg::REG_DECRYPT_MODE, 32'h0);
      end
      1: begin
        for (int k = 0; k < 4; k++) cfg_write(KEY_REGS[k], 32'hffffffff);
        cfg_write(sm4_pkg::REG_DECRYPT_MODE, 32'h1);
      end
      default: begin
        case ($urandom_range(0, 3))
          0: for (int k = 0; k < 4; k++) cfg_write(KEY_REGS[k], $urandom);
          1: cfg_write(KEY_REGS[$urandom_range(0, 3)], rand_word());
          2: ;
          default: for (int k = 0; k < 4; k++) cfg_write(KEY_REGS[k], rand_word());
        endcase
        if ($urandom_range(0, 2) != 0) cfg_write(sm4_pkg::REG_DECRYPT_MODE, $urandom);
        if ($urandom_range(0, 3) == 0) begin
          cfg_write(sm4_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                    $urandom);
        end
      end
    endcase
  endtask

  initial begin : stimulus
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    known_pending = 1'b0;
    known_ans     = '0;
    idle_on       = 1'b1;
    hold_req      = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        settle();
        cfg_write(DIRECTED[r].idx, DIRECTED[r].data);
      end else begin
        send_block(DIRECTED[r].blk, DIRECTED[r].known, DIRECTED[r].ans);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      idle_on = (ph < PHASES - QUIET_PHASES);
      settle();
      retune(ph);
      // long output hold while blocks keep coming
      if (ph == 3) hold_req = 1'b1;
      for (int n = 0; n < PHASE_BLOCKS; n++) begin
        if (ph == 6 && n == PHASE_BLOCKS / 2) settle();
        send_block(rand_block(), 1'b0, '0);
      end
    end

    settle();
    repeat (48) @(negedge clk);

    $display("run covered %0d blocks (%0d against typed answers), %0d key word loads,",
             blocks_checked, known_checked, key_loads);
    $display("%0d register writes, %0d random phases with one long output hold",
             reg_writes, PHASES);
    if (fault_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
